// File: src/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked property with the reset as disable condition.
`define DEQ_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Checked property that also holds during reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`else

`define DEQ_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

// File: src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Used by deq_store, deq_ctrl and the top level; depends on nothing.
package deq_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Access request from the controller to the slot memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

// File: src/deq_store.sv
// Slot memory of the double-ended queue: one write and one registered read port.
// Depends on deq_pkg for the word width and the access request type.
module deq_store import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                     clk,
  input  mem_cmd_t                 cmd,
  input  logic [IW-1:0]            wr_addr,
  input  logic signed [WORD_W-1:0] wr_data,
  input  logic [IW-1:0]            rd_addr,
  output logic signed [WORD_W-1:0] rd_data
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/deq_ctrl.sv
// Front pointer, fill count and result registers of the double-ended queue.
// Depends on deq_pkg and on the assertion macros in double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       operation,
  output logic             busy,
  output mem_cmd_t         cmd,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    rd_addr,
  output logic             done,
  output logic             pop_ok,
  output logic [1:0]       status,
  output logic [OCC_W-1:0] occupancy
);

  localparam int SW = CW + 1;

  logic [IW-1:0] front;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  status_t       status_next;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] back_pos;
  logic [SW-1:0] last_sum;
  logic [SW-1:0] last_pos;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;

  assign accept   = start && !busy;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // Ring positions: slot after the back word, and the back word itself.
  always_comb begin
    back_sum = SW'(front) + SW'(count);
    back_pos = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    last_sum = SW'(front) + SW'(count) - SW'(1);
    last_pos = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
    front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
    front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  end

  // Decode the operation into a memory access and the next pointer state.
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    cmd         = '0;
    wr_addr     = IW'(back_pos);
    rd_addr     = front;
    unique case (op_t'(operation))
      OP_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          cmd.wr_en  = accept;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          cmd.wr_en  = accept;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.rd_en  = accept;
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      OP_POP_BACK: begin
        rd_addr = IW'(last_pos);
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.rd_en  = accept;
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // State and result registers; the result is registered in the cycle after its item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      count  <= '0;
      busy   <= 1'b1;
      done   <= 1'b0;
      pop_ok <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        front     <= front_next;
        count     <= count_next;
        pop_ok    <= cmd.rd_en;
        status    <= status_next;
        occupancy <= OCC_W'(count_next);
      end
    end
  end

  `DEQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "fill count exceeds depth")
  `DEQ_ASSERT(a_result_follows, clk, rst, accept |=> done, "accepted item gave no result")
  `DEQ_ASSERT(a_no_stray_result, clk, rst, done |-> $past(accept), "result without an item")
  `DEQ_ASSERT_ALWAYS(a_one_access, clk, !(cmd.wr_en && cmd.rd_en), "read and write at once")
  `DEQ_ASSERT(a_empty_status, clk, rst,
    (done && status == ST_EMPTY) |-> (occupancy == '0 && !pop_ok),
    "empty status with stored words")

endmodule

// File: src/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words in a ring buffer.
// Depends on deq_pkg, deq_ctrl and deq_store.
//
// Usage:
//   An item (operation, push_value) is taken at a rising edge where start is
//   high and busy is low. Operations: push front, push back, pop front,
//   pop back. Every item gives one result on pop_value, status and occupancy,
//   marked by done for exactly one cycle, in the cycle after the item was
//   taken. The receiver cannot stall; each result must be taken when shown.
//   The popped word comes from the registered read port of the slot memory.
//   Throughput is one item per cycle while busy is low: pointers and the fill
//   count update at the accepting edge, so the next item sees them at once.
//   A pop returns the stored word with status ok, or 0 with status empty on
//   an empty queue. A push returns 0; on a full queue the word is dropped
//   and status reads full. Occupancy is the fill count after the item, kept
//   to five bits.
//   Synchronous reset empties the queue; busy is high during reset and falls
//   at the first clock edge after it. The slot memory is not cleared.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     done,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [1:0]               status,
  output logic [OCC_W-1:0]         occupancy
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mem_cmd_t                 cmd;
  logic [IW-1:0]            wr_addr;
  logic [IW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic                     pop_ok;

  deq_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .busy     (busy),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .done     (done),
    .pop_ok   (pop_ok),
    .status   (status),
    .occupancy(occupancy)
  );

  deq_store #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_store (
    .clk    (clk),
    .cmd    (cmd),
    .wr_addr(wr_addr),
    .wr_data(push_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Only a successful pop shows the word read from memory.
  assign pop_value = pop_ok ? rd_data : '0;

endmodule
